// ===== src/paged_word_checksum_core_macros.svh =====
// Assertion macros shared by the paged word checksum RTL.
`ifndef PAGED_WORD_CHECKSUM_CORE_MACROS_SVH
`define PAGED_WORD_CHECKSUM_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define PWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define PWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/pwc_pkg.sv =====
// Shared types, constants and helper functions of the paged word checksum core.
`default_nettype none

package pwc_pkg;

    // Field widths.
    localparam int WORD_W       = 32;
    localparam int PAGE_WORDS_W = 11;
    localparam int PAGE_SUM_W   = 17;
    localparam int TOTAL_W      = 32;
    localparam int FOLD_W       = 16;
    localparam int ACC_W        = WORD_W + 1;

    // Stream data widths (output padded to whole bytes).
    localparam int S_TDATA_W = WORD_W;
    localparam int M_TDATA_W = ((PAGE_SUM_W + TOTAL_W + 1 + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_WORDS     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_TOTAL = 1'b1;

    // Reset values and default sizing.
    localparam logic [PAGE_WORDS_W-1:0] PAGE_WORDS_RESET = 11'd1024;
    localparam logic [TOTAL_W-1:0]      EXPECTED_RESET   = '0;
    localparam int                      DEF_MAX_PAGE_WORDS = 1024;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [PAGE_WORDS_W-1:0] page_words;
        logic [TOTAL_W-1:0]      expected_total;
    } t_cfg;

    // One page result.
    typedef struct packed {
        logic [PAGE_SUM_W-1:0] page_sum;
        logic [TOTAL_W-1:0]    running_total;
        logic                  is_final;
        logic                  total_matches;
    } t_result;

    // Fold a 33-bit end-around-carry sum down to 16 bits.
    function automatic logic [FOLD_W-1:0] fold16(input logic [ACC_W-1:0] acc);
        logic [FOLD_W+1:0] s1;
        logic [FOLD_W+1:0] s2;
        s1 = (FOLD_W+2)'(acc[FOLD_W-1:0]) + (FOLD_W+2)'(acc[ACC_W-1:FOLD_W]);
        s2 = s1 + (FOLD_W+2)'(s1[FOLD_W+1:FOLD_W]);
        return s2[FOLD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/pwc_cfg_regs.sv =====
// Configuration register file: page size and expected section total.
`default_nettype none

module pwc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [pwc_pkg::CFG_ADDR_W-1:0] i_addr,
    input  wire logic [pwc_pkg::CFG_DATA_W-1:0] i_wdata,
    output pwc_pkg::t_cfg                      o_cfg
);
    import pwc_pkg::*;

    logic [PAGE_WORDS_W-1:0] r_page_words;
    logic [TOTAL_W-1:0]      r_expected;

    // Register writes, decoded by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_words <= PAGE_WORDS_RESET;
            r_expected   <= EXPECTED_RESET;
        end else if (i_we) begin
            case (i_addr)
                CFG_PAGE_WORDS:     r_page_words <= i_wdata[PAGE_WORDS_W-1:0];
                CFG_EXPECTED_TOTAL: r_expected   <= i_wdata[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.page_words     = r_page_words;
    assign o_cfg.expected_total = r_expected;

endmodule

`default_nettype wire

// ===== src/pwc_page_accum.sv =====
// Page accumulator: end-around-carry sum, word count, fold and section total.
`default_nettype none

`include "paged_word_checksum_core_macros.svh"

module pwc_page_accum #(
    parameter int MAX_PAGE_WORDS = pwc_pkg::DEF_MAX_PAGE_WORDS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [pwc_pkg::WORD_W-1:0] i_word,
    input  wire logic                      i_last,
    input  pwc_pkg::t_cfg                  i_cfg,
    output logic                           o_close,
    output pwc_pkg::t_result               o_result
);
    import pwc_pkg::*;

    localparam int CW = $clog2(MAX_PAGE_WORDS + 1);
    localparam int LW = (CW > PAGE_WORDS_W) ? CW : PAGE_WORDS_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAGE_WORDS);
    localparam logic [LW-1:0] MAX_LIM = LW'(MAX_PAGE_WORDS);

    logic [ACC_W-1:0]   r_acc;
    logic [CW-1:0]      r_words;
    logic [TOTAL_W-1:0] r_total;

    logic [ACC_W-1:0]      acc_raw;
    logic [ACC_W-1:0]      n_acc;
    logic [CW-1:0]         n_words;
    logic [LW-1:0]         pw_ext;
    logic [LW-1:0]         limit;
    logic [FOLD_W-1:0]     folded;
    logic [PAGE_SUM_W-1:0] psum;
    logic [TOTAL_W-1:0]    sum_total;

    // End-around-carry add; a second carry is folded back once.
    always_comb begin
        acc_raw = ACC_W'(r_acc[WORD_W-1:0]) + ACC_W'(i_word) + ACC_W'(r_acc[WORD_W]);
        if (acc_raw[WORD_W] && (acc_raw[WORD_W-1:0] != '0)) begin
            n_acc = ACC_W'(acc_raw[WORD_W-1:0]) + ACC_W'(1'b1);
        end else begin
            n_acc = acc_raw;
        end
    end

    // Word count saturates at the largest page.
    assign n_words = (r_words < MAX_CNT) ? r_words + 1'b1 : r_words;

    // Effective page size: zero acts as one, large values saturate.
    always_comb begin
        pw_ext = LW'(i_cfg.page_words);
        if (pw_ext == '0) begin
            limit = LW'(1'b1);
        end else if (pw_ext > MAX_LIM) begin
            limit = MAX_LIM;
        end else begin
            limit = pw_ext;
        end
    end

    assign o_close = i_last || (LW'(n_words) >= limit);

    // Page checksum and running total.
    assign folded    = fold16(n_acc);
    assign psum      = PAGE_SUM_W'(folded) + PAGE_SUM_W'({n_words, 2'b00});
    assign sum_total = r_total + TOTAL_W'(psum);

    assign o_result.page_sum      = psum;
    assign o_result.running_total = sum_total;
    assign o_result.is_final      = i_last;
    assign o_result.total_matches = i_last && (sum_total == i_cfg.expected_total);

    // State update; a closed page clears, a closed section clears the total too.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_words <= '0;
            r_total <= '0;
        end else if (i_step) begin
            if (o_close) begin
                r_acc   <= '0;
                r_words <= '0;
                r_total <= i_last ? '0 : sum_total;
            end else begin
                r_acc   <= n_acc;
                r_words <= n_words;
            end
        end
    end

    `PWC_ASSERT_NOW(a_acc_bound, i_clk, i_rst_n, r_acc[WORD_W], r_acc[WORD_W-1:0] == '0, "accumulator above 2^32")
    `PWC_ASSERT_NOW(a_words_bound, i_clk, i_rst_n, 1'b1, r_words < MAX_CNT, "open page at word limit")
    `PWC_ASSERT_NEXT(a_page_clear, i_clk, i_rst_n, i_step && o_close, r_words == '0 && r_acc == '0, "closed page not cleared")
    `PWC_ASSERT_NEXT(a_total_clear, i_clk, i_rst_n, i_step && i_last, r_total == '0, "section total not cleared")

endmodule

`default_nettype wire

// ===== src/paged_word_checksum_core.sv =====
// Top level of the paged word checksum core: stream ports, beat register, result register.
//
//   Channel   Dir  Payload (lowest bit first)                         Marker
//   s_axis    in   tdata: code_word[31:0]                               tlast: section_end
//   m_axis    out  tdata: page_sum[16:0], running_total[48:17],
//                         total_matches[49], zero pad [55:50]           tlast: is_final
//   cfg       in   index 0: page_words[10:0], index 1: expected_total   write on i_cfg_we
//
// One word per cycle is sustained unless a stall on m_axis holds a closing beat; a page result is
// valid on m_axis once its closing beat has passed the beat register, then the result register.
// The page accumulator loop (33-bit add, fold and total add) sets the clock rate.
// Reset is synchronous; there is no clearing pass.
// A stall on m_axis holds the result; beats that close no page still advance.
`default_nettype none

`include "paged_word_checksum_core_macros.svh"

module paged_word_checksum_core #(
    parameter int MAX_PAGE_WORDS = pwc_pkg::DEF_MAX_PAGE_WORDS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input words.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [pwc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // code_word
    input  wire logic                          s_axis_tlast,  // section_end
    // Page results.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [pwc_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // page_sum, running_total,
                                                              // total_matches, pad
    output logic                               m_axis_tlast,  // is_final
    // Configuration writes.
    input  wire logic                          i_cfg_we,
    input  wire logic [pwc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pwc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pwc_pkg::*;

    t_cfg    cfg;
    t_result result;
    logic    close;
    logic    advance;

    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;

    pwc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    pwc_page_accum #(
        .MAX_PAGE_WORDS (MAX_PAGE_WORDS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in_word),
        .i_last   (r_in_last),
        .i_cfg    (cfg),
        .o_close  (close),
        .o_result (result)
    );

    // A held beat moves on unless it closes a page while the result slot is occupied and not being taken.
    assign advance       = r_in_valid && (!close || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && close) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && close) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.is_final;
    assign m_axis_tdata  = M_TDATA_W'({r_out.total_matches, r_out.running_total, r_out.page_sum});

    `PWC_ASSERT_NOW(a_match_final, i_clk, i_rst_n, r_out_valid && r_out.total_matches, r_out.is_final, "match flag on a non-final page")
    `PWC_ASSERT_NEXT(a_beat_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid, "held beat dropped")
    `PWC_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid, "pending result dropped")
    `PWC_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, advance && close && r_out_valid, m_axis_tready, "result overwritten")

endmodule

`default_nettype wire
